// File: hdl/assert_macros.svh
// Assertion macros used by the accumulator top-level RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while rst is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/psw_pkg.sv
// Types and constants of the pulse shape waveform accumulator
package psw_pkg;

  localparam int DIV_W   = 42;               // widest dividend: 4*amp*k
  localparam int DVS_W   = 32;               // widest divisor: n*n
  localparam int DCNT_W  = $clog2(DIV_W);
  localparam int BIN_VAL_W = 32;
  localparam int SHARE_W = 26;               // a share never exceeds 2*amp

  localparam logic FUNC_DEPOSIT = 1'b0;
  localparam logic FUNC_READ    = 1'b1;

  localparam logic CFG_SHAPE_MODE = 1'b0;
  localparam logic CFG_BIN_WIDTH  = 1'b1;

  localparam logic MODE_SQUARE = 1'b0;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DVS_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_W-1:0]     quotient;
  } div_rsp_t;

endpackage

// File: hdl/psw_div.sv
// Restoring divider, one quotient bit per cycle
module psw_div (
  input  logic              clk,
  input  logic              rst,
  input  psw_pkg::div_req_t req,
  output psw_pkg::div_rsp_t rsp
);
  import psw_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DIV_W-1:0]  quo;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic              done;
  logic [DVS_W:0]    shifted;
  logic              fits;

  assign shifted = {rem, quo[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? DVS_W'(shifted - {1'b0, dvs}) : shifted[DVS_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: hdl/psw_mem.sv
// Waveform bin memory, one write and one registered read port
module psw_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic [psw_pkg::BIN_VAL_W-1:0]   wdata,
  input  logic                            re,
  input  logic [AW-1:0]                   raddr,
  output logic [psw_pkg::BIN_VAL_W-1:0]   rdata
);
  import psw_pkg::*;

  logic [BIN_VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/pulse_shape_waveform_accumulator_top.sv
// Pulse shape waveform accumulator: sequencer around a shared divider
//
//  port group  dir  content
//  s_*         in   deposit or read item
//  m_*         out  bin read back (one per read item)
//  cfg_*       in   register writes
//
// After reset a clearing pass writes every bin, with s_tready low. A deposit
// divides for its start bin and its length in bins, then for each covered bin
// multiplies, divides for the share and writes the bin back, all on the one
// bit-per-cycle divider (DIV_W = 42) that serves every division; a deposit with
// zero amplitude or length or a bad channel is dropped. A read whose result finds
// m_tvalid still high waits until it is taken.
module pulse_shape_waveform_accumulator_top #(
  parameter int NUM_BINS     = 1024,
  parameter int NUM_CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // channel, time_ns, amplitude, length_ns, bin_index
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // bin_value, read_channel, read_bin
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import psw_pkg::*;
  `include "assert_macros.svh"

  localparam int DEPTH = NUM_CHANNELS * NUM_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BCW   = $clog2(NUM_BINS + 1) > 17 ? $clog2(NUM_BINS + 1) : 17;

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_RD_REQ  = 4'd2;
  localparam logic [3:0] ST_RD_DATA = 4'd3;
  localparam logic [3:0] ST_START_W = 4'd4;
  localparam logic [3:0] ST_N_W     = 4'd5;
  localparam logic [3:0] ST_NN      = 4'd6;
  localparam logic [3:0] ST_BIN_MUL = 4'd7;
  localparam logic [3:0] ST_BIN_DIV = 4'd8;
  localparam logic [3:0] ST_BIN_W   = 4'd9;
  localparam logic [3:0] ST_DIV_ST  = 4'd10;

  logic [3:0]  state;
  logic        shape_mode;
  logic [7:0]  bin_width;
  logic [7:0]  bw;

  logic        func;
  logic [3:0]  channel;
  logic [15:0] time_ns;
  logic [23:0] amplitude;
  logic [15:0] length_ns;
  logic [9:0]  bin_index;
  logic        item_ok;

  logic [16:0]    start_bin;
  logic [15:0]    n;
  logic [31:0]    nn;
  logic [BCW-1:0] b;
  logic [BCW-1:0] last;
  logic [15:0]    k;
  logic [39:0]    prod;
  logic [AW-1:0]  clr_addr;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [BIN_VAL_W-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [BIN_VAL_W-1:0] mem_rdata;

  logic [31:0]     addr_wide;
  logic [AW-1:0]   addr;
  logic [BIN_VAL_W:0] sum;
  logic [16:0]     end_bin;
  logic [BCW-1:0]  b_inc;
  logic [16:0]     twok;
  logic [16:0]     n17;

  assign bw        = (bin_width == 8'd0) ? 8'd1 : bin_width;
  assign addr_wide = 32'(channel) * 32'(NUM_BINS)
                   + 32'((func == FUNC_READ) ? BCW'(bin_index) : b);
  assign addr      = addr_wide[AW-1:0];
  assign sum       = {1'b0, mem_rdata} + (BIN_VAL_W + 1)'(div_rsp.quotient[SHARE_W-1:0]);
  assign end_bin   = start_bin + 17'(n);
  assign b_inc     = b + 1'b1;
  assign twok      = {k, 1'b0};
  assign n17       = {1'b0, n};

  assign s_tready = (state == ST_IDLE);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode <= 1'b1;
      bin_width  <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHAPE_MODE: shape_mode <= cfg_wdata[0];
        CFG_BIN_WIDTH:  bin_width  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // divider operands
  always_comb begin
    div_req = '0;
    unique case (state)
      ST_DIV_ST: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(time_ns);
        div_req.divisor  = DVS_W'(bw);
      end
      ST_START_W: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = DIV_W'(17'(length_ns) + 17'(bw) - 17'd1);
        div_req.divisor  = DVS_W'(bw);
      end
      ST_BIN_DIV: begin
        div_req.start = 1'b1;
        if (shape_mode == MODE_SQUARE) begin
          div_req.dividend = DIV_W'(amplitude);
          div_req.divisor  = DVS_W'(n);
        end else if (twok == n17) begin
          div_req.dividend = DIV_W'({amplitude, 1'b0});
          div_req.divisor  = DVS_W'(n);
        end else begin
          div_req.dividend = {prod, 2'b00};
          div_req.divisor  = nn;
        end
      end
      default: ;
    endcase
  end

  psw_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = addr;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      ST_RD_REQ:  mem_re = item_ok;
      ST_RD_DATA: mem_we = item_ok && !m_tvalid;
      ST_BIN_MUL: mem_re = 1'b1;
      ST_BIN_W: begin
        mem_we    = div_rsp.done;
        mem_wdata = sum[BIN_VAL_W] ? '1 : sum[BIN_VAL_W-1:0];
      end
      default: ;
    endcase
  end

  psw_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == FUNC_READ) begin
              state <= ST_RD_REQ;
            end else if (32'(s_tdata[3:0]) < NUM_CHANNELS && s_tdata[43:20] != '0
                         && s_tdata[59:44] != '0) begin
              state <= ST_DIV_ST;
            end
          end
        end
        ST_RD_REQ: state <= ST_RD_DATA;
        ST_RD_DATA: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_DIV_ST: state <= ST_START_W;
        ST_START_W: begin
          if (div_rsp.done) begin
            state <= ST_N_W;
          end
        end
        ST_N_W: begin
          if (div_rsp.done) begin
            state <= ST_NN;
          end
        end
        ST_NN: begin
          state <= (32'(start_bin) >= NUM_BINS) ? ST_IDLE : ST_BIN_MUL;
        end
        ST_BIN_MUL: state <= ST_BIN_DIV;
        ST_BIN_DIV: state <= ST_BIN_W;
        ST_BIN_W: begin
          if (div_rsp.done) begin
            state <= (b_inc == last) ? ST_IDLE : ST_BIN_MUL;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item fields and datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      func      <= s_tuser;
      channel   <= s_tdata[3:0];
      time_ns   <= s_tdata[19:4];
      amplitude <= s_tdata[43:20];
      length_ns <= s_tdata[59:44];
      bin_index <= s_tdata[69:60];
      item_ok   <= 32'(s_tdata[3:0]) < NUM_CHANNELS && 32'(s_tdata[69:60]) < NUM_BINS;
    end
    if (state == ST_START_W && div_rsp.done) begin
      start_bin <= div_rsp.quotient[16:0];
    end
    if (state == ST_N_W && div_rsp.done) begin
      n <= div_rsp.quotient[15:0];
    end
    if (state == ST_NN) begin
      nn   <= 32'(n) * 32'(n);
      b    <= BCW'(start_bin);
      k    <= '0;
      last <= (32'(end_bin) > NUM_BINS) ? BCW'(NUM_BINS) : BCW'(end_bin);
    end
    if (state == ST_BIN_MUL) begin
      // rising side uses k, falling side n-k
      prod <= 40'(amplitude) * 40'((twok < n17) ? k : (n - k));
    end
    if (state == ST_BIN_W && div_rsp.done) begin
      b <= b_inc;
      k <= k + 1'b1;
    end
    if (state == ST_RD_DATA && !m_tvalid) begin
      m_tdata <= {2'b00, bin_index, channel, item_ok ? mem_rdata : {BIN_VAL_W{1'b0}}};
    end
  end

  `ASSERT_CLK(a_no_item_in_clear, state == ST_CLEAR |-> !s_tready, "item taken during clear")
  `ASSERT_CLK(a_result_from_read, $rose(m_tvalid) |-> $past(state) == ST_RD_DATA,
              "result not from a read")
  `ASSERT_CLK(a_bin_write_in_range, (state == ST_BIN_W && div_rsp.done) |-> b < last,
              "bin write past the end")

endmodule

// File: tb/sv/pulse_shape_waveform_accumulator_top_tb.sv
// Testbench for the pulse shape waveform accumulator: directed and random deposits and reads
module pulse_shape_waveform_accumulator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psw_pkg::*;

  localparam int  N_BINS        = 1024;
  localparam int  N_CHANNELS    = 16;
  localparam logic MODE_TRIANGLE = 1'b1;
  localparam int  STALL_LIMIT   = 400000;
  localparam int  MAX_REPORTS   = 10;

  typedef struct {
    logic [31:0] bin_value;
    logic [3:0]  read_channel;
    logic [9:0]  read_bin;
  } bin_read_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  // local copy of the block's state
  logic [31:0] wave_bins [N_CHANNELS*N_BINS];
  logic        shape_mode_q;
  logic [7:0]  bin_width_q;

  bin_read_t   pending_reads[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          rdy_wait = 0;
  bit          sender_burst = 0;
  bit          receiver_burst = 0;

  pulse_shape_waveform_accumulator_top u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_wdata
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void deposit_pulse(logic [3:0] ch, logic [15:0] t, logic [23:0] amp,
                                        logic [15:0] len);
    longint unsigned bw, start, n, last, nn, k, share, sum;
    int idx;
    bw = (bin_width_q == 0) ? 1 : bin_width_q;
    if (amp == 0 || len == 0) return;
    start = t / bw;
    n = (len + bw - 1) / bw;
    last = start + n;
    if (last > N_BINS) last = N_BINS;
    nn = n * n;
    for (longint unsigned b = start; b < last; b++) begin
      k = b - start;
      if (shape_mode_q == MODE_SQUARE) share = amp / n;
      else if (2 * k < n) share = (4 * amp * k) / nn;
      else if (2 * k != n) share = (4 * amp * (n - k)) / nn;
      else share = (2 * amp) / n;
      idx = ch * N_BINS + int'(b);
      sum = wave_bins[idx] + share;
      wave_bins[idx] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    end
  endfunction

  function automatic void read_and_clear(logic [3:0] ch, logic [9:0] bin);
    bin_read_t r;
    int idx;
    idx = ch * N_BINS + bin;
    r.bin_value    = wave_bins[idx];
    r.read_channel = ch;
    r.read_bin     = bin;
    wave_bins[idx] = '0;
    pending_reads.push_back(r);
  endfunction

  // result side: random stalls, check each item against the oldest expectation
  always @(posedge clk) begin
    bin_read_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result item: tdata=%h", m_tdata);
      end else begin
        e = pending_reads.pop_front();
        if (m_tdata[31:0] !== e.bin_value || m_tdata[35:32] !== e.read_channel ||
            m_tdata[45:36] !== e.read_bin) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp value=%h ch=%0d bin=%0d, got value=%h ch=%0d bin=%0d",
                     e.bin_value, e.read_channel, e.read_bin,
                     m_tdata[31:0], m_tdata[35:32], m_tdata[45:36]);
        end
      end
      if ($urandom_range(0, 31) == 0) receiver_burst = !receiver_burst;
      rdy_wait = receiver_burst ? 0 : $urandom_range(0, 15);
      m_tready <= (rdy_wait == 0);
    end else if (rdy_wait > 0) begin
      rdy_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_SHAPE_MODE) shape_mode_q = value[0];
    else bin_width_q = value;
  endtask

  task automatic send_item(logic func, logic [3:0] ch, logic [15:0] t, logic [23:0] amp,
                           logic [15:0] len, logic [9:0] bin);
    int gap;
    if ($urandom_range(0, 31) == 0) sender_burst = !sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {2'b00, bin, len, amp, t, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (func == FUNC_DEPOSIT) deposit_pulse(ch, t, amp, len);
    else read_and_clear(ch, bin);
  endtask

  // sender holds off until all reads are back; a trailing read proves the
  // block has finished any deposit still in flight
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    send_item(FUNC_READ, 4'($urandom_range(0, 15)), '0, '0, '0, 10'($urandom_range(0, 1023)));
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_default_triangle();
    // reset values: triangle, bin width 2
    send_item(FUNC_DEPOSIT, 4'd0, 16'd0, 24'd1000, 16'd10, '0);     // odd n = 5
    send_item(FUNC_DEPOSIT, 4'd1, 16'd3, 24'd4096, 16'd8, '0);      // even n = 4, exact middle
    for (int b = 0; b < 6; b++) send_item(FUNC_READ, 4'd0, '0, '0, '0, 10'(b));
    for (int b = 1; b < 6; b++) send_item(FUNC_READ, 4'd1, '0, '0, '0, 10'(b));
    send_item(FUNC_DEPOSIT, 4'd2, 16'd4, 24'd0, 16'd20, '0);        // zero amplitude
    send_item(FUNC_DEPOSIT, 4'd2, 16'd4, 24'd5000, 16'd0, '0);      // zero length
    send_item(FUNC_DEPOSIT, 4'd2, 16'hFFFF, 24'hFFFFFF, 16'd6, '0); // start past the end
    send_item(FUNC_DEPOSIT, 4'd15, 16'd2046, 24'hFFFFFF, 16'd40, '0); // clipped at last bin
    send_item(FUNC_READ, 4'd2, '0, '0, '0, 10'd2);
    send_item(FUNC_READ, 4'd15, '0, '0, '0, 10'd1023);
    send_item(FUNC_READ, 4'd15, '0, '0, '0, 10'd1023);
    drain();
  endtask

  task automatic test_square_zero_width();
    write_reg(CFG_SHAPE_MODE, 8'hFE);  // only bit 0 counts
    write_reg(CFG_BIN_WIDTH, 8'd0);    // behaves as width 1
    send_item(FUNC_DEPOSIT, 4'd3, 16'd10, 24'd999, 16'd3, '0);
    for (int b = 9; b < 14; b++) send_item(FUNC_READ, 4'd3, '0, '0, '0, 10'(b));
    drain();
  endtask

  task automatic test_saturation();
    write_reg(CFG_BIN_WIDTH, 8'd1);
    for (int i = 0; i < 260; i++)
      send_item(FUNC_DEPOSIT, 4'd5, 16'd7, 24'hFFFFFF, 16'd1, '0);
    send_item(FUNC_READ, 4'd5, '0, '0, '0, 10'd7);
    send_item(FUNC_READ, 4'd5, '0, '0, '0, 10'd7);
    drain();
  endtask

  task automatic random_items(int count);
    int unsigned bw, n, sbin;
    logic [15:0] t, len;
    logic [23:0] amp;
    logic [3:0]  ch;
    logic [9:0]  bin;
    for (int i = 0; i < count; i++) begin
      ch = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 6) begin
        bw = (bin_width_q == 0) ? 1 : bin_width_q;
        sbin = $urandom_range(0, 48);
        t = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(sbin * bw + $urandom_range(0, bw - 1));
        n = $urandom_range(1, 20);
        len = 16'((n - 1) * bw + $urandom_range(1, bw));
        if ($urandom_range(0, 39) == 0) len = 16'($urandom);
        else if ($urandom_range(0, 29) == 0) len = 16'd0;
        amp = ($urandom_range(0, 19) == 0) ? 24'd0 : 24'($urandom);
        send_item(FUNC_DEPOSIT, ch, t, amp, len, 10'($urandom));
      end else begin
        bin = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 70));
        send_item(FUNC_READ, ch, 16'($urandom), 24'($urandom), 16'($urandom), bin);
      end
    end
  endtask

  task automatic test_random_phases();
    logic [7:0] widths [7] = '{8'd1, 8'd1, 8'd255, 8'd255, 8'd0, 8'd3, 8'd0};
    widths[5] = 8'($urandom_range(2, 254));
    widths[6] = 8'($urandom_range(2, 16));
    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_SHAPE_MODE, 8'((p % 2 == 0) ? MODE_TRIANGLE : MODE_SQUARE));
      write_reg(CFG_BIN_WIDTH, widths[p]);
      random_items(36);
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < N_CHANNELS * N_BINS; i++) wave_bins[i] = '0;
    shape_mode_q = MODE_TRIANGLE;
    bin_width_q  = 8'd2;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_triangle();
    test_square_zero_width();
    test_saturation();
    test_random_phases();
    s_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_reads.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
